[src/bms_pkg.sv]
// ----------------------------------------------------------------------------
// bms_pkg
// shared types and constants of the batch median sorter
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int SAMPLE_W            = 32;
    localparam int DEFAULT_MAX_SAMPLES = 64;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // operation applied to every cell of the chain at once
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

endpackage

[src/batch_median_sorter.sv]
// ----------------------------------------------------------------------------
// batch_median_sorter
// streaming median of a batch of signed Q16.16 samples
// ----------------------------------------------------------------------------
// Samples enter one per transfer (start high while busy is low) and are placed
// in a row of MAX_SAMPLES cells kept in ascending order; a sample goes after
// any equal ones, and one without last_sample leaves the block idle, so such
// samples stream at one per clock. On the sample flagged last_sample the block
// raises busy and shifts the row toward cell 0 until the middle element(s) sit
// in cells 0 and 1 (no shift for an empty row), then forms the result and
// drops busy. The result appears on median and overflow for one cycle with
// done high; the receiver cannot stall it, and a new batch may start in that
// same cycle. An odd count gives the middle element, an even count the floor
// of the mean of the two middle ones. Samples arriving with the row full are
// dropped and flagged on overflow. Count and flag clear after each result;
// cell contents are not cleared since only filled cells are ever used.
// ----------------------------------------------------------------------------
module batch_median_sorter #(
    parameter int MAX_SAMPLES = bms_pkg::DEFAULT_MAX_SAMPLES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [31:0]         sample,
    input  logic                       last_sample,
    output logic                       done,
    output logic signed [31:0]         median,
    output logic                       overflow
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int REM_W = $clog2(MAX_SAMPLES);

    // control state
    bms_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              odd_reg, odd_next;
    logic              empty_reg, empty_next;
    logic              done_reg, done_next;

    // result payload
    bms_pkg::sample_t  median_reg, median_next;
    logic              overflow_reg, overflow_next;

    // cell row
    bms_pkg::cell_op_t cell_op;
    bms_pkg::sample_t  cell_val [MAX_SAMPLES];
    logic              cell_gt  [MAX_SAMPLES];

    logic              accept;
    logic              full;
    logic [CNT_W-1:0]  count_after;
    logic [CNT_W-1:0]  half_n;
    logic signed [32:0] pair_sum;

    assign accept      = start && (state_reg == bms_pkg::ST_IDLE);
    assign full        = (count_reg == CNT_W'(MAX_SAMPLES));
    assign count_after = full ? count_reg : count_reg + CNT_W'(1);
    assign half_n      = count_after >> 1;
    assign pair_sum    = {cell_val[0][31], cell_val[0]} + {cell_val[1][31], cell_val[1]};

    // row of insertion cells, each compares itself with the incoming sample
    for (genvar i = 0; i < MAX_SAMPLES; i++)
    begin : g_cell
        bms_pkg::sample_t left_v;
        bms_pkg::sample_t right_v;
        logic             left_g;
        logic             occ;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_v = cell_val[i];
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_v = cell_val[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == MAX_SAMPLES - 1)
        begin : g_last
            assign right_v = cell_val[i];
        end
        else
        begin : g_inner
            assign right_v = cell_val[i+1];
        end

        bms_cell u_cell (
            .clk        (clk),
            .op         (cell_op),
            .new_sample (sample),
            .occupied   (occ),
            .left_val   (left_v),
            .left_gt    (left_g),
            .right_val  (right_v),
            .val        (cell_val[i]),
            .gt         (cell_gt[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bms_pkg::ST_IDLE:
                if (accept && last_sample)
                    state_next = bms_pkg::ST_SHIFT;
            bms_pkg::ST_SHIFT:
                if (rem_reg == '0)
                    state_next = bms_pkg::ST_IDLE;
            default:
                state_next = bms_pkg::ST_IDLE;
        endcase
    end

    // datapath control and outputs
    always_comb
    begin
        cell_op       = bms_pkg::CELL_HOLD;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        rem_next      = rem_reg;
        odd_next      = odd_reg;
        empty_next    = empty_reg;
        done_next     = 1'b0;
        median_next   = median_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            bms_pkg::ST_IDLE:
                if (accept)
                begin
                    cell_op      = full ? bms_pkg::CELL_HOLD : bms_pkg::CELL_INSERT;
                    count_next   = count_after;
                    dropped_next = dropped_reg | full;
                    odd_next     = count_after[0];
                    empty_next   = (count_after == '0);
                    // shifts needed to bring the lower middle element to cell 0
                    if (count_after[0] || count_after == '0)
                        rem_next = REM_W'(half_n);
                    else
                        rem_next = REM_W'(half_n - CNT_W'(1));
                end
            bms_pkg::ST_SHIFT:
                if (rem_reg == '0)
                begin
                    done_next     = 1'b1;
                    overflow_next = dropped_reg;
                    if (empty_reg)
                        median_next = '0;
                    else if (odd_reg)
                        median_next = cell_val[0];
                    else
                        median_next = pair_sum[32:1];
                    count_next    = '0;
                    dropped_next  = 1'b0;
                end
                else
                begin
                    cell_op  = bms_pkg::CELL_SHIFT;
                    rem_next = rem_reg - REM_W'(1);
                end
            default:
                cell_op = bms_pkg::CELL_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bms_pkg::ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            rem_reg     <= '0;
            odd_reg     <= 1'b0;
            empty_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            rem_reg     <= rem_next;
            odd_reg     <= odd_next;
            empty_reg   <= empty_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg   <= median_next;
        overflow_reg <= overflow_next;
    end

    assign busy     = (state_reg != bms_pkg::ST_IDLE);
    assign done     = done_reg;
    assign median   = median_reg;
    assign overflow = overflow_reg;

    // a result follows only the final cycle of a shift walk
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == bms_pkg::ST_SHIFT) && $past(rem_reg == '0))
        else $error("result strobe without a finished shift walk");

    // the fill count never passes the row length
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond capacity");

    // a transfer marked last always starts the median walk
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_sample |=> busy)
        else $error("last sample did not start the median walk");

    // the two middle elements reach cells 0 and 1 in order
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bms_pkg::ST_SHIFT) && (rem_reg == '0) && !odd_reg && !empty_reg
        |-> cell_val[0] <= cell_val[1])
        else $error("middle elements out of order");

endmodule

[src/bms_cell.sv]
// ----------------------------------------------------------------------------
// bms_cell
// one slot of the sorted chain: holds a sample, inserts or shifts toward cell 0
// ----------------------------------------------------------------------------
module bms_cell (
    input  logic                clk,
    input  bms_pkg::cell_op_t   op,
    input  bms_pkg::sample_t    new_sample,
    input  logic                occupied,
    input  bms_pkg::sample_t    left_val,
    input  logic                left_gt,
    input  bms_pkg::sample_t    right_val,
    output bms_pkg::sample_t    val,
    output logic                gt
);

    bms_pkg::sample_t val_reg;
    bms_pkg::sample_t val_next;

    // empty slots count as larger than any sample
    assign gt  = !occupied || (val_reg > new_sample);
    assign val = val_reg;

    always_comb
    begin
        case (op)
            bms_pkg::CELL_INSERT:
            begin
                if (!gt)
                    val_next = val_reg;
                else if (left_gt)
                    val_next = left_val;
                else
                    val_next = new_sample;
            end
            bms_pkg::CELL_SHIFT:
                val_next = right_val;
            default:
                val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[tb/tb_batch_median_sorter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_batch_median_sorter
// self-checking bench for the streaming batch median sorter
// ----------------------------------------------------------------------------
// A short table of directed transfers covers the sample extremes, equal
// samples and the rounding of even-count medians. Random batches follow.
// Most of them are short, some fill the row, and a few run past capacity so
// that samples, the last one included, are dropped. Every accepted sample goes
// through an insertion-sort model kept here. Each done strobe is checked
// against the oldest pending median.
// ----------------------------------------------------------------------------
module tb_batch_median_sorter;

    localparam int      CAP        = bms_pkg::DEFAULT_MAX_SAMPLES;
    localparam int      DIR_N      = 23;
    localparam int      ITEM_GOAL  = 1650;
    localparam int      DRAIN_WAIT = 40;        // longest busy stretch plus margin
    localparam int      CYCLE_LIMIT = 400000;
    localparam bms_pkg::sample_t S_MAX = 32'sh7FFF_FFFF;
    localparam bms_pkg::sample_t S_MIN = 32'sh8000_0000;

    // one directed transfer; known marks a median typed in by hand
    typedef struct packed {
        bms_pkg::sample_t smp;
        logic             lst;
        logic             known;
        bms_pkg::sample_t med;
        logic             ovf;
    } stim_row_t;

    typedef struct {
        bms_pkg::sample_t med;
        logic             ovf;
    } median_res_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    bms_pkg::sample_t sample;
    logic             last_sample;
    logic             done;
    bms_pkg::sample_t median;
    logic             overflow;

    // sorted copy of the batch held by the block
    bms_pkg::sample_t row_vals [CAP];
    int unsigned      row_len;
    logic             row_dropped;

    median_res_t median_q [$];      // medians still to come out of the block
    stim_row_t   dir_tab [DIR_N];
    int          mismatch_cnt;
    int          cycle_cnt;
    int          items_sent;

    batch_median_sorter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .sample      (sample),
        .last_sample (last_sample),
        .done        (done),
        .median      (median),
        .overflow    (overflow)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // insert one sample after any equal ones; on the last one form the median
    function automatic bit absorb_sample(input bms_pkg::sample_t s, input logic lst,
                                         output median_res_t res);
        int unsigned        pos;
        int unsigned        n;
        logic signed [32:0] pair_sum;
        res.med = '0;
        res.ovf = 1'b0;
        if (row_len < CAP)
        begin
            pos = row_len;
            while (pos > 0 && row_vals[pos-1] > s)
            begin
                row_vals[pos] = row_vals[pos-1];
                pos--;
            end
            row_vals[pos] = s;
            row_len++;
        end
        else
            row_dropped = 1'b1;
        if (!lst)
            return 1'b0;
        n = row_len;
        if (n > 0)
        begin
            if (n % 2 == 1)
                res.med = row_vals[n/2];
            else
            begin
                // 33-bit sum, arithmetic halving rounds toward minus infinity
                pair_sum = {row_vals[n/2-1][31], row_vals[n/2-1]}
                         + {row_vals[n/2][31], row_vals[n/2]};
                res.med = pair_sum[32:1];
            end
        end
        res.ovf     = row_dropped;
        row_len     = 0;
        row_dropped = 1'b0;
        return 1'b1;
    endfunction

    // drive one sample after gap idle cycles and hold it until the transfer;
    // start stays high across back-to-back transfers so it is never lowered
    // and raised in the same step
    task automatic send_sample(input bms_pkg::sample_t s, input logic lst, input int gap,
                               input logic known, input bms_pkg::sample_t kmed,
                               input logic kovf);
        median_res_t res;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        sample      <= s;
        last_sample <= lst;
        // transfer happens at the first edge that sees busy low
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (absorb_sample(s, lst, res))
        begin
            if (known)
            begin
                res.med = kmed;
                res.ovf = kovf;
            end
            median_q.push_back(res);
        end
    endtask

    // hold the sender off until every pending median has been seen
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (median_q.size() != 0)
            @(posedge clk);
    endtask

    // result checker: done is a one-cycle strobe that cannot be held off
    always @(posedge clk)
    begin
        median_res_t want;
        if (rst_n && done)
        begin
            if (median_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: median %0d overflow %0b",
                             median, overflow);
            end
            else
            begin
                want = median_q.pop_front();
                if (median !== want.med || overflow !== want.ovf)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"mismatch: expected median %0d overflow %0b,",
                                  " got median %0d overflow %0b"},
                                 want.med, want.ovf, median, overflow);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAIL batch_median_sorter");
            $finish;
        end
    end

    initial
    begin
        int               batch_len;
        int               batch_idx;
        int               value_mode;
        int               sel;
        bit               quiet;
        bms_pkg::sample_t val;

        rst_n        = 1'b0;
        start        = 1'b0;
        sample       = '0;
        last_sample  = 1'b0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        items_sent   = 0;
        row_len      = 0;
        row_dropped  = 1'b0;
        batch_idx    = 0;

        // directed transfers: single-sample extremes, extreme pairs, rounding
        // of negative and odd sums, descending input, equal samples, Q16.16
        dir_tab = '{
            '{S_MAX,           1'b1, 1'b1, S_MAX,      1'b0},
            '{S_MIN,           1'b1, 1'b1, S_MIN,      1'b0},
            '{32'sd0,          1'b1, 1'b1, 32'sd0,     1'b0},
            '{S_MAX,           1'b0, 1'b0, 32'sd0,     1'b0},
            '{S_MIN,           1'b1, 1'b1, -32'sd1,    1'b0},
            '{S_MAX,           1'b0, 1'b0, 32'sd0,     1'b0},
            '{S_MAX,           1'b1, 1'b1, S_MAX,      1'b0},
            '{S_MIN,           1'b0, 1'b0, 32'sd0,     1'b0},
            '{S_MIN,           1'b1, 1'b1, S_MIN,      1'b0},
            '{-32'sd1,         1'b0, 1'b0, 32'sd0,     1'b0},
            '{-32'sd2,         1'b1, 1'b0, 32'sd0,     1'b0},
            '{32'sd30,         1'b0, 1'b0, 32'sd0,     1'b0},
            '{32'sd20,         1'b0, 1'b0, 32'sd0,     1'b0},
            '{32'sd10,         1'b1, 1'b0, 32'sd0,     1'b0},
            '{32'sd5,          1'b0, 1'b0, 32'sd0,     1'b0},
            '{32'sd5,          1'b0, 1'b0, 32'sd0,     1'b0},
            '{32'sd5,          1'b0, 1'b0, 32'sd0,     1'b0},
            '{32'sd5,          1'b1, 1'b0, 32'sd0,     1'b0},
            '{32'sd1,          1'b0, 1'b0, 32'sd0,     1'b0},
            '{32'sd2,          1'b1, 1'b0, 32'sd0,     1'b0},
            '{32'shFFFF_8000,  1'b0, 1'b0, 32'sd0,     1'b0},
            '{32'sh0001_0000,  1'b0, 1'b0, 32'sd0,     1'b0},
            '{32'sh0002_0000,  1'b1, 1'b0, 32'sd0,     1'b0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_sample(dir_tab[i].smp, dir_tab[i].lst, $urandom_range(0, 3),
                        dir_tab[i].known, dir_tab[i].med, dir_tab[i].ovf);

        // let the directed medians all come out before the random part
        drain_results();

        // random batches: mostly short, some filling the row exactly,
        // a few running past capacity
        while (items_sent < ITEM_GOAL)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                batch_len = $urandom_range(1, 12);
            else if (sel < 88)
                batch_len = $urandom_range(13, CAP - 1);
            else if (sel < 94)
                batch_len = $urandom_range(CAP, CAP + 1);
            else
                batch_len = $urandom_range(CAP + 2, CAP + 16);
            value_mode = $urandom_range(0, 3);
            quiet      = ($urandom_range(0, 9) < 3);

            for (int k = 0; k < batch_len; k++)
            begin
                case (value_mode)
                    0: val = $urandom();
                    1: val = $signed($urandom_range(0, 8)) - 32'sd4;  // many duplicates
                    2: val = $urandom_range(0, 1) ? S_MAX : S_MIN;
                    default: val = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                    16'($urandom())};               // near zero in Q16.16
                endcase
                send_sample(val, k == batch_len - 1,
                            quiet ? 0 : $urandom_range(0, 17), 1'b0, '0, 1'b0);
            end

            batch_idx++;
            if (batch_idx % 16 == 0)
                drain_results();
        end

        start <= 1'b0;
        while (median_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_cnt == 0 && median_q.size() == 0)
            $display("PASS batch_median_sorter");
        else
            $display("FAIL batch_median_sorter");
        $finish;
    end

endmodule
